>>> src/xtc_pkg.sv
// Shared types, constants and register indexes for the XYZ to chromaticity block.
package xtc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Denominator and remainder width: X + 15Y + 3Z with 31-bit components
    localparam int DEN_W = 36;
    // Widest dividend: 9Y with a 31-bit Y
    localparam int NUM_W = 35;

    localparam logic [1:0] CFG_CLAMP_EN = 2'd0;
    localparam logic [1:0] CFG_WHITE_X  = 2'd1;
    localparam logic [1:0] CFG_WHITE_Y  = 2'd2;
    localparam logic [1:0] CFG_WHITE_Z  = 2'd3;

    localparam logic [30:0] WHITE_X_RST = 31'd62290;
    localparam logic [30:0] WHITE_Y_RST = 31'd65536;
    localparam logic [30:0] WHITE_Z_RST = 31'd71358;

    typedef struct packed {
        logic signed [31:0] tri_x_in;
        logic signed [31:0] tri_y_in;
        logic signed [31:0] tri_z_in;
    } t_xyz_in;

    typedef struct packed {
        logic [30:0] tri_x_out;
        logic [30:0] tri_y_out;
        logic [30:0] tri_z_out;
        logic [16:0] chroma_x;
        logic [16:0] chroma_y;
        logic [17:0] u_prime;
        logic [16:0] v_prime;
        logic        legal_flag;
        logic        black_flag;
    } t_xyz_out;

    // Values that ride alongside the dividers
    typedef struct packed {
        logic [30:0] x;
        logic [30:0] y;
        logic [30:0] z;
        logic        legal;
        logic        black;
        logic        yzero;
    } t_side;

endpackage

>>> src/xtc_div_cell.sv
// One restoring-division cell: resolves one quotient bit and hands on to the next cell.
module xtc_div_cell
    import xtc_pkg::*;
#(
    parameter int QB = FRAC_BITS_DEF + 4
) (
    input  logic             i_clk,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [DEN_W-1:0] i_den,
    input  logic [QB-1:0]    i_bits,
    input  logic [QB-1:0]    i_quo,
    output logic [DEN_W-1:0] o_rem,
    output logic [DEN_W-1:0] o_den,
    output logic [QB-1:0]    o_bits,
    output logic [QB-1:0]    o_quo
);

    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        w_trial = {i_rem, i_bits[QB-1]};
        w_ge    = w_trial >= {1'b0, i_den};
        w_diff  = w_trial - {1'b0, i_den};
        // remainder stays below the divisor, so the top bit drops out
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= n_rem;
        o_den  <= i_den;
        o_bits <= {i_bits[QB-2:0], 1'b0};
        o_quo  <= {i_quo[QB-2:0], w_ge};
    end

endmodule

>>> src/xyz_to_chromaticity.sv
// Top level: XYZ pixel to corrected XYZ, xy chromaticity and u'v'.
//
// Usage
//   Raise i_start with a pixel on i_pixel; the transaction is taken at any
//   clock edge where i_start is high and o_busy is low. o_busy is tied low:
//   a new pixel may be offered on every cycle.
//   Each result appears on o_result for exactly one cycle with o_done high.
//   There is no back-pressure; the receiver must take it in that cycle.
// Pipeline and throughput
//   One pixel per cycle. The edge that takes a pixel registers it
//   rationalised and clamped; a second register forms sums and
//   dividends; four parallel chains of FRAC_BITS + 4 division cells
//   resolve one quotient bit per cell; a final register rounds and
//   saturates. The chain length sets the latency.
// Configuration
//   i_cfg_we writes i_cfg_data to register i_cfg_idx at the clock edge;
//   write only while no pixel is in flight.
// Reset
//   Synchronous, active low. Clears all in-flight transactions and loads
//   the D65 white point with clamping off.
module xyz_to_chromaticity
    import xtc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_xyz_in     i_pixel,
    output logic        o_busy,
    output logic        o_done,
    output t_xyz_out    o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    localparam int QB = FRAC_BITS + 4;
    localparam int NL = 4;
    localparam logic [QB-1:0] ONE_Q  = QB'(1) << FRAC_BITS;
    localparam logic [QB-1:0] UMAX_Q = (QB'(4) << FRAC_BITS) - QB'(1);

    // configuration
    logic        r_clamp_en;
    logic [30:0] r_wx, r_wy, r_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_en <= 1'b0;
            r_wx       <= WHITE_X_RST;
            r_wy       <= WHITE_Y_RST;
            r_wz       <= WHITE_Z_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLAMP_EN: r_clamp_en <= i_cfg_data[0];
                CFG_WHITE_X:  r_wx       <= i_cfg_data;
                CFG_WHITE_Y:  r_wy       <= i_cfg_data;
                CFG_WHITE_Z:  r_wz       <= i_cfg_data;
                default:      r_clamp_en <= r_clamp_en;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // stage 1: legality, rationalise, clamp
    logic        w_acc;
    logic        w_xn, w_yn, w_zn, w_xzr, w_yzr, w_over, w_bad;
    logic [30:0] w_x0, w_y0, w_z0, w_x1, w_y1, w_z1;
    logic [30:0] n_s1_x, n_s1_y, n_s1_z;
    logic        n_s1_legal;

    always_comb begin
        w_acc = i_start && !o_busy;
        w_xn  = i_pixel.tri_x_in[31];
        w_yn  = i_pixel.tri_y_in[31];
        w_zn  = i_pixel.tri_z_in[31];
        w_x0  = w_xn ? 31'd0 : i_pixel.tri_x_in[30:0];
        w_y0  = w_yn ? 31'd0 : i_pixel.tri_y_in[30:0];
        w_z0  = w_zn ? 31'd0 : i_pixel.tri_z_in[30:0];
        w_xzr = i_pixel.tri_x_in == 32'sd0;
        w_yzr = i_pixel.tri_y_in == 32'sd0;
        w_bad = (w_yzr && (w_x0 != 31'd0 || w_z0 != 31'd0)) ||
                (!w_yzr && w_xzr) || w_xn || w_yn || w_zn;
        w_over = r_clamp_en && (w_x0 > r_wx || w_y0 > r_wy || w_z0 > r_wz);
        n_s1_legal = !w_bad && !w_over;
        // clear X and Z without luminance, clear all with luminance but no X
        w_x1 = (w_y0 == 31'd0) ? 31'd0 : w_x0;
        w_z1 = (w_y0 == 31'd0 || w_x0 == 31'd0) ? 31'd0 : w_z0;
        w_y1 = (w_x0 == 31'd0) ? 31'd0 : w_y0;
        n_s1_x = (r_clamp_en && w_x1 > r_wx) ? r_wx : w_x1;
        n_s1_y = (r_clamp_en && w_y1 > r_wy) ? r_wy : w_y1;
        n_s1_z = (r_clamp_en && w_z1 > r_wz) ? r_wz : w_z1;
    end

    logic        r_s1_vld;
    logic [30:0] r_s1_x, r_s1_y, r_s1_z;
    logic        r_s1_legal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc;
        end
        r_s1_x     <= n_s1_x;
        r_s1_y     <= n_s1_y;
        r_s1_z     <= n_s1_z;
        r_s1_legal <= n_s1_legal;
    end

    // stage 2: sums and dividends, load the division chains
    logic [DEN_W-1:0] w_sum, w_den;
    logic [NUM_W-1:0] w_num [NL];
    t_side            n_s2_side;

    always_comb begin
        w_sum = DEN_W'(r_s1_x) + DEN_W'(r_s1_y) + DEN_W'(r_s1_z);
        w_den = DEN_W'(r_s1_x) + (DEN_W'(r_s1_y) << 4) - DEN_W'(r_s1_y)
              + (DEN_W'(r_s1_z) << 1) + DEN_W'(r_s1_z);
        w_num[0] = NUM_W'(r_s1_x);
        w_num[1] = NUM_W'(r_s1_y);
        w_num[2] = NUM_W'(r_s1_x) << 2;
        w_num[3] = (NUM_W'(r_s1_y) << 3) + NUM_W'(r_s1_y);
        n_s2_side.x     = r_s1_x;
        n_s2_side.y     = r_s1_y;
        n_s2_side.z     = r_s1_z;
        n_s2_side.legal = r_s1_legal;
        n_s2_side.black = r_s1_x == 31'd0 && r_s1_y == 31'd0 && r_s1_z == 31'd0;
        n_s2_side.yzero = r_s1_y == 31'd0;
    end

    logic [DEN_W-1:0] w_rem  [NL][QB+1];
    logic [DEN_W-1:0] w_dv   [NL][QB+1];
    logic [QB-1:0]    w_bits [NL][QB+1];
    logic [QB-1:0]    w_quo  [NL][QB+1];

    logic [DEN_W-1:0] r_s2_rem  [NL];
    logic [DEN_W-1:0] r_s2_den  [NL];
    logic [QB-1:0]    r_s2_bits [NL];

    // dividend is num << (FRAC_BITS + 1); its top part already sits below the divisor
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r_s2_rem[l]  <= DEN_W'(w_num[l] >> 3);
            r_s2_den[l]  <= (l < 2) ? w_sum : w_den;
            r_s2_bits[l] <= {w_num[l][2:0], (QB-3)'(0)};
        end
    end

    genvar gl, gs;
    generate
        for (gl = 0; gl < NL; gl++) begin : g_lane
            assign w_rem[gl][0]  = r_s2_rem[gl];
            assign w_dv[gl][0]   = r_s2_den[gl];
            assign w_bits[gl][0] = r_s2_bits[gl];
            assign w_quo[gl][0]  = '0;
            for (gs = 0; gs < QB; gs++) begin : g_cell
                xtc_div_cell #(.QB(QB)) u_cell (
                    .i_clk  (i_clk),
                    .i_rem  (w_rem[gl][gs]),
                    .i_den  (w_dv[gl][gs]),
                    .i_bits (w_bits[gl][gs]),
                    .i_quo  (w_quo[gl][gs]),
                    .o_rem  (w_rem[gl][gs+1]),
                    .o_den  (w_dv[gl][gs+1]),
                    .o_bits (w_bits[gl][gs+1]),
                    .o_quo  (w_quo[gl][gs+1])
                );
            end
        end
    endgenerate

    // side band delay matching the chains: index 0 is stage 2
    logic  r_vld  [QB+1];
    t_side r_side [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) r_vld[s] <= 1'b0;
        end else begin
            r_vld[0] <= r_s1_vld;
            for (int s = 1; s <= QB; s++) r_vld[s] <= r_vld[s-1];
        end
        r_side[0] <= n_s2_side;
        for (int s = 1; s <= QB; s++) r_side[s] <= r_side[s-1];
    end

    // output stage: round to nearest, ties up, then saturate; zero Y clears the chromaticity
    logic [QB-1:0] w_rnd [NL];
    logic [QB-1:0] w_cx, w_cy, w_up, w_vp;
    t_side         w_fin;
    t_xyz_out      n_result;

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            w_rnd[l] = QB'(({1'b0, w_quo[l][QB]} + (QB+1)'(1)) >> 1);
        end
        w_fin = r_side[QB];
        w_cx = (w_rnd[0] > ONE_Q)  ? ONE_Q  : w_rnd[0];
        w_cy = (w_rnd[1] > ONE_Q)  ? ONE_Q  : w_rnd[1];
        w_up = (w_rnd[2] > UMAX_Q) ? UMAX_Q : w_rnd[2];
        w_vp = (w_rnd[3] > ONE_Q)  ? ONE_Q  : w_rnd[3];
        if (w_fin.yzero) begin
            w_cx = '0;
            w_cy = '0;
            w_up = '0;
            w_vp = '0;
        end
        n_result.tri_x_out  = w_fin.x;
        n_result.tri_y_out  = w_fin.y;
        n_result.tri_z_out  = w_fin.z;
        n_result.chroma_x   = 17'(w_cx);
        n_result.chroma_y   = 17'(w_cy);
        n_result.u_prime    = 18'(w_up);
        n_result.v_prime    = 17'(w_vp);
        n_result.legal_flag = w_fin.legal;
        n_result.black_flag = w_fin.black;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_vld[QB];
        end
        o_result <= n_result;
    end

endmodule

>>> src/xtc_checker.sv
// Port-level checks for the XYZ to chromaticity block, bound to the top level.
module xtc_checker
    import xtc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_start,
    input logic     o_busy,
    input logic     o_done,
    input t_xyz_out o_result
);

    localparam int LAT = FRAC_BITS + 7;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");

    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LAT))
        else $error("result without a transaction");

    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.black_flag) |->
        (o_result.chroma_x == 17'd0 && o_result.chroma_y == 17'd0 &&
         o_result.u_prime == 18'd0 && o_result.v_prime == 17'd0))
        else $error("black pixel with chromaticity");

    a_y_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.tri_y_out == 31'd0) |->
        (o_result.chroma_x == 17'd0 && o_result.v_prime == 17'd0))
        else $error("zero luminance with chromaticity");

endmodule

bind xyz_to_chromaticity xtc_checker #(.FRAC_BITS(FRAC_BITS)) u_xtc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);

>>> tb/sv/tb_xyz_to_chromaticity.sv
// Self-checking testbench for the XYZ to chromaticity block.
`timescale 1ns / 1ps

module tb_xyz_to_chromaticity;
    import xtc_pkg::*;

    // Predicts corrected XYZ, chromaticity and u'v' for each pixel and holds
    // the predictions until the matching result comes out of the pipeline.
    class chroma_scoreboard;
        logic        clamp_en;
        logic [30:0] wx, wy, wz;
        t_xyz_out    pending_q[$];
        int          errors;

        function new();
            clamp_en = 1'b0;
            wx = WHITE_X_RST;
            wy = WHITE_Y_RST;
            wz = WHITE_Z_RST;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [30:0] data);
            case (idx)
                CFG_CLAMP_EN: clamp_en = data[0];
                CFG_WHITE_X:  wx = data;
                CFG_WHITE_Y:  wy = data;
                default:      wz = data;
            endcase
        endfunction

        // Round to nearest with ties upward; zero divisor gives zero.
        function logic [63:0] rdiv(logic [63:0] num, logic [63:0] den);
            if (den == 0) return 64'd0;
            return (2 * num + den) / (2 * den);
        endfunction

        function logic [63:0] cap(logic [63:0] v, logic [63:0] m);
            return (v > m) ? m : v;
        endfunction

        function void note_pixel(t_xyz_in p);
            t_xyz_out    r;
            logic [30:0] x, y, z;
            logic        xn, yn, zn, legal;
            logic [63:0] sum, den, one;
            xn = p.tri_x_in[31];
            yn = p.tri_y_in[31];
            zn = p.tri_z_in[31];
            x = xn ? 31'd0 : p.tri_x_in[30:0];
            y = yn ? 31'd0 : p.tri_y_in[30:0];
            z = zn ? 31'd0 : p.tri_z_in[30:0];
            one = 64'd1 << 16;
            legal = 1'b1;
            // legality is judged on the raw words, before any correction
            if (p.tri_y_in == 0 && (x != 0 || z != 0)) legal = 1'b0;
            else if (p.tri_y_in != 0 && p.tri_x_in == 0) legal = 1'b0;
            else if (xn || yn || zn) legal = 1'b0;
            if (clamp_en && (x > wx || y > wy || z > wz)) legal = 1'b0;
            if (y == 0) begin
                x = 0;
                z = 0;
            end
            if (y != 0 && x == 0) begin
                y = 0;
                z = 0;
            end
            if (clamp_en) begin
                if (x > wx) x = wx;
                if (y > wy) y = wy;
                if (z > wz) z = wz;
            end
            r = '0;
            r.tri_x_out = x;
            r.tri_y_out = y;
            r.tri_z_out = z;
            if (y != 0) begin
                sum = 64'(x) + 64'(y) + 64'(z);
                den = 64'(x) + 15 * 64'(y) + 3 * 64'(z);
                r.chroma_x = 17'(cap(rdiv(64'(x) << 16, sum), one));
                r.chroma_y = 17'(cap(rdiv(64'(y) << 16, sum), one));
                r.u_prime  = 18'(cap(rdiv((4 * 64'(x)) << 16, den), (one << 2) - 1));
                r.v_prime  = 17'(cap(rdiv((9 * 64'(y)) << 16, den), one));
            end
            r.legal_flag = legal;
            r.black_flag = (x == 0 && y == 0 && z == 0);
            pending_q.push_back(r);
        endfunction

        function void check_result(t_xyz_out got);
            t_xyz_out e;
            if (pending_q.size() == 0) begin
                $error("result with no pixel outstanding");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.tri_x_out !== e.tri_x_out) fail("tri_x_out", e.tri_x_out, got.tri_x_out);
            if (got.tri_y_out !== e.tri_y_out) fail("tri_y_out", e.tri_y_out, got.tri_y_out);
            if (got.tri_z_out !== e.tri_z_out) fail("tri_z_out", e.tri_z_out, got.tri_z_out);
            if (got.chroma_x !== e.chroma_x) fail("chroma_x", e.chroma_x, got.chroma_x);
            if (got.chroma_y !== e.chroma_y) fail("chroma_y", e.chroma_y, got.chroma_y);
            if (got.u_prime !== e.u_prime) fail("u_prime", e.u_prime, got.u_prime);
            if (got.v_prime !== e.v_prime) fail("v_prime", e.v_prime, got.v_prime);
            if (got.legal_flag !== e.legal_flag)
                fail("legal_flag", e.legal_flag, got.legal_flag);
            if (got.black_flag !== e.black_flag)
                fail("black_flag", e.black_flag, got.black_flag);
        endfunction

        function void fail(string field, logic [63:0] exp_v, logic [63:0] act_v);
            $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
            errors++;
        endfunction
    endclass

    localparam int PIPE_DEPTH = 23;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    t_xyz_in     i_pixel = '0;
    logic        o_busy;
    logic        o_done;
    t_xyz_out    o_result;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_CLAMP_EN;
    logic [30:0] i_cfg_data = '0;

    chroma_scoreboard sb;
    int unsigned      cycle_count = 0;

    xyz_to_chromaticity u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_pixel   (i_pixel),
        .o_busy    (o_busy),
        .o_done    (o_done),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Check every result in the cycle it is presented; the block never waits.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) sb.check_result(o_result);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Write one register while the pipeline is empty, then drop the write enable and idle before returning.
    task automatic write_cfg(logic [1:0] idx, logic [30:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Offer one pixel, after a random gap when gaps is set; hold it until the transaction is taken.
    task automatic send_pixel(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
        int   gap;
        logic taken;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_pixel <= '{x, y, z};
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_busy;
            @(negedge i_clk);
        end
        sb.note_pixel('{x, y, z});
    endtask

    // Drop start, then wait for the pipeline to drain before touching registers.
    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 4) @(negedge i_clk);
    endtask

    // Random component: mostly positive and near the white point, sometimes
    // wide, negative or zero.
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom | 32'h8000_0000;
            2, 3:    return {1'b0, 31'($urandom)};
            4:       return 32'($urandom_range(1, 255));
            default: return 32'($urandom_range(1, 200000));
        endcase
    endfunction

    // Phase of random pixels, mostly legal ones with Y and X nonzero.
    task automatic random_phase(int count);
        logic [31:0] x, y, z;
        bit          gaps;
        for (int n = 0; n < count; n++) begin
            // alternate stretches with and without idle cycles
            gaps = ((n / 40) % 2) == 0;
            x = rand_comp();
            y = rand_comp();
            z = rand_comp();
            if ($urandom_range(0, 3) != 0) begin
                x = 32'($urandom_range(1, 200000));
                y = 32'($urandom_range(1, 200000));
                z = 32'($urandom_range(0, 200000));
            end
            send_pixel(x, y, z, gaps);
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes of each field and every correction rule.
        send_pixel(32'd0, 32'd0, 32'd0, 0);                        // black
        send_pixel(32'd5, 32'd0, 32'd9, 0);                        // zero Y with X and Z
        send_pixel(32'd0, 32'd65536, 32'd100, 0);                  // zero X, Y nonzero
        send_pixel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0); // most negative
        send_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0); // most positive
        send_pixel(32'h7FFF_FFFF, 32'd1, 32'd0, 0);                // u' saturation
        send_pixel(32'd1, 32'h7FFF_FFFF, 32'd0, 0);
        send_pixel(32'd62290, 32'd65536, 32'd71358, 0);            // white point
        send_pixel(32'd100, 32'hFFFF_FFFF, 32'd100, 0);            // negative Y
        send_pixel(32'hFFFF_FFFF, 32'd100, 32'hFFFF_0000, 1);      // negative X and Z
        send_pixel(32'd1, 32'd1, 32'd1, 1);
        send_pixel(32'd1, 32'd1, 32'd0, 1);                        // x and y exactly one half
        drain();

        // Clamp on with the default white point.
        write_cfg(CFG_CLAMP_EN, 31'd1);
        send_pixel(32'd70000, 32'd70000, 32'd80000, 0);            // above every limit
        send_pixel(32'd62290, 32'd65536, 32'd71358, 0);            // exactly on limits
        send_pixel(32'h7FFF_FFFF, 32'd5, 32'h7FFF_FFFF, 1);
        random_phase(250);
        drain();

        // Zero white limits: clamped Y of zero must zero the chromaticity.
        write_cfg(CFG_WHITE_X, 31'd0);
        write_cfg(CFG_WHITE_Y, 31'd0);
        write_cfg(CFG_WHITE_Z, 31'd0);
        send_pixel(32'd100, 32'd100, 32'd100, 0);
        send_pixel(32'd0, 32'd0, 32'd0, 0);
        random_phase(60);
        drain();

        // Largest limits and a mixed setting.
        write_cfg(CFG_WHITE_X, 31'h7FFF_FFFF);
        write_cfg(CFG_WHITE_Y, 31'h7FFF_FFFF);
        write_cfg(CFG_WHITE_Z, 31'h7FFF_FFFF);
        send_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        random_phase(200);
        drain();
        write_cfg(CFG_WHITE_X, 31'($urandom_range(1000, 150000)));
        write_cfg(CFG_WHITE_Y, 31'($urandom_range(1000, 150000)));
        write_cfg(CFG_WHITE_Z, 31'($urandom_range(1000, 150000)));
        random_phase(250);
        drain();

        // Clamp off again with odd limits left behind.
        write_cfg(CFG_CLAMP_EN, 31'd0);
        random_phase(330);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
